/* rtl/core/presence_change_tracking_table_top_macros.svh */
// Assertion macros for the presence change tracking table.
// Included by presence_change_tracking_table_top.sv; no other dependencies.
`ifndef PRESENCE_CHANGE_TRACKING_TABLE_TOP_MACROS_SVH
`define PRESENCE_CHANGE_TRACKING_TABLE_TOP_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define PCTT_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pctt: assertion failed");

// Same-cycle implication.
`define PCTT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pctt: assertion failed");

// Next-cycle implication.
`define PCTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pctt: assertion failed");

`endif

/* rtl/core/pctt_pkg.sv */
// Package for the presence change tracking table: defaults, event codes,
// and the control structs shared by the cell and the top level. No dependencies.
package pctt_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [1:0] {
    EV_ADDED   = 2'd0,
    EV_CHANGED = 2'd1,
    EV_DELETED = 2'd2,
    EV_DONE    = 2'd3
  } pctt_event_t;

  // Controls common to the whole chain.
  typedef struct packed {
    logic shift_marks;
    logic tok_move;
  } pctt_chain_ctrl_t;

  // Per-cell write enables.
  typedef struct packed {
    logic write_key;
    logic write_data;
    logic set_now;
  } pctt_cell_cmd_t;

endpackage

/* rtl/core/pctt_cell.sv */
// One table entry of the presence change tracking table: key, timestamp,
// size, presence marks and the sweep token. Depends on pctt_pkg.
module pctt_cell #(
  parameter int KEY_BITS = pctt_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pctt_pkg::pctt_chain_ctrl_t ctrl,
  input  pctt_pkg::pctt_cell_cmd_t   cmd,
  input  logic [KEY_BITS-1:0]       key_in,
  input  logic [31:0]               time_in,
  input  logic [31:0]               size_in,
  input  logic                      tok_in,
  output logic                      hit,
  output logic                      free,
  output logic                      del,
  output logic                      tok,
  output logic [KEY_BITS-1:0]       st_key,
  output logic [31:0]               st_time,
  output logic [31:0]               st_size
);

  logic seen_before;
  logic seen_now;

  assign free = !(seen_before || seen_now);
  assign hit  = !free && (st_key == key_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_before <= 1'b0;
      seen_now    <= 1'b0;
      del         <= 1'b0;
      tok         <= 1'b0;
    end else begin
      if (ctrl.shift_marks) begin
        del         <= seen_before && !seen_now;
        seen_before <= seen_now;
        seen_now    <= 1'b0;
      end else if (cmd.set_now) begin
        seen_now <= 1'b1;
      end
      if (ctrl.tok_move) begin
        tok <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_key) begin
      st_key <= key_in;
    end
    if (cmd.write_data) begin
      st_time <= time_in;
      st_size <= size_in;
    end
  end

endmodule

/* rtl/core/presence_change_tracking_table_top.sv */
// Top level of the presence change tracking table: command FSM over a chain
// of pctt_cell entries. Depends on pctt_pkg, pctt_cell and the macros header.
//
// A report (cmd 0) is taken when start is high and busy low; busy then stays
// high through the lookup in every cell and the update of the matching or
// first free cell, and no new command is taken until busy falls. ADDED or
// CHANGED comes out in the same cycle as busy falls; a report that repeats
// the stored timestamp, or misses on a full table, produces nothing. An end
// of scan (cmd 1) shifts the presence marks at once and then walks a token
// down the chain one cell per cycle, keeping busy high until the token has
// passed the last cell and DONE is issued. DELETED results appear as the
// token passes each vanished entry, in slot order, followed by DONE with
// last set. Results are held for exactly one cycle with strobe high and
// cannot be stalled.
module presence_change_tracking_table_top #(
  parameter int ENTRIES  = pctt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = pctt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [31:0] item_key,
  input  logic [31:0] mod_time,
  input  logic [31:0] item_size,
  output logic        strobe,
  output logic [1:0]  event_res,
  output logic [4:0]  slot,
  output logic [31:0] out_key,
  output logic [31:0] out_time,
  output logic [31:0] out_size,
  output logic        last
);

`include "presence_change_tracking_table_top_macros.svh"

  localparam int IDX_W = $clog2(ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_ACT   = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         time_q;
  logic [31:0]         size_q;
  logic                load_in;

  logic [ENTRIES-1:0]  hit, free, del, tok;
  logic [ENTRIES-1:0]  hit_q, ff_q, sel;
  logic [KEY_BITS-1:0] st_key  [ENTRIES];
  logic [31:0]         st_time [ENTRIES];
  logic [31:0]         st_size [ENTRIES];

  pctt_pkg::pctt_chain_ctrl_t chain_ctrl;
  pctt_pkg::pctt_cell_cmd_t   cell_cmd [ENTRIES];
  logic                       tok_inject;

  logic [KEY_BITS-1:0] sel_key;
  logic [31:0]         sel_time;
  logic [31:0]         sel_size;
  logic [IDX_W-1:0]    sel_idx;

  logic                  strobe_next;
  pctt_pkg::pctt_event_t ev_next;
  logic [4:0]            slot_next;
  logic [31:0]           key_next;
  logic [31:0]           time_next;
  logic [31:0]           size_next;
  logic                  last_next;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pctt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (chain_ctrl),
      .cmd    (cell_cmd[g]),
      .key_in (key_q),
      .time_in(time_q),
      .size_in(size_q),
      .tok_in ((g == 0) ? tok_inject : tok[(g == 0) ? 0 : g - 1]),
      .hit    (hit[g]),
      .free   (free[g]),
      .del    (del[g]),
      .tok    (tok[g]),
      .st_key (st_key[g]),
      .st_time(st_time[g]),
      .st_size(st_size[g])
    );
  end

  assign busy = (state != ST_IDLE);

  // one-hot read select and slot encode
  always_comb begin
    priority if (state == ST_SWEEP) begin
      sel = tok;
    end else if (|hit_q) begin
      sel = hit_q;
    end else begin
      sel = ff_q;
    end
    sel_key  = '0;
    sel_time = '0;
    sel_size = '0;
    sel_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        sel_key  = sel_key | st_key[i];
        sel_time = sel_time | st_time[i];
        sel_size = sel_size | st_size[i];
        sel_idx  = sel_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    chain_ctrl  = '0;
    tok_inject  = 1'b0;
    load_in     = 1'b0;
    strobe_next = 1'b0;
    ev_next     = pctt_pkg::EV_ADDED;
    slot_next   = 5'(sel_idx);
    key_next    = 32'(key_q);
    time_next   = time_q;
    size_next   = size_q;
    last_next   = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      cell_cmd[i] = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd) begin
            chain_ctrl.shift_marks = 1'b1;
            chain_ctrl.tok_move    = 1'b1;
            tok_inject             = 1'b1;
            state_next             = ST_SWEEP;
          end else begin
            load_in    = 1'b1;
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        state_next = ST_ACT;
      end
      ST_ACT: begin
        state_next = ST_IDLE;
        if (|hit_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            cell_cmd[i].set_now    = hit_q[i];
            cell_cmd[i].write_data = hit_q[i] && (sel_time != time_q);
          end
          if (sel_time != time_q) begin
            strobe_next = 1'b1;
            ev_next     = pctt_pkg::EV_CHANGED;
          end
        end else if (|ff_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            cell_cmd[i].write_key  = ff_q[i];
            cell_cmd[i].write_data = ff_q[i];
            cell_cmd[i].set_now    = ff_q[i];
          end
          strobe_next = 1'b1;
          ev_next     = pctt_pkg::EV_ADDED;
        end
      end
      ST_SWEEP: begin
        chain_ctrl.tok_move = 1'b1;
        ev_next             = pctt_pkg::EV_DELETED;
        key_next            = 32'(sel_key);
        time_next           = sel_time;
        size_next           = sel_size;
        last_next           = 1'b0;
        strobe_next         = |(tok & del);
        if (tok[ENTRIES-1]) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        strobe_next = 1'b1;
        ev_next     = pctt_pkg::EV_DONE;
        slot_next   = '0;
        key_next    = '0;
        time_next   = '0;
        size_next   = '0;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      key_q  <= KEY_BITS'(item_key);
      time_q <= mod_time;
      size_q <= item_size;
    end
    if (state == ST_LOOK) begin
      hit_q <= hit;
      ff_q  <= free & (~free + ENTRIES'(1));
    end
    event_res <= ev_next;
    slot      <= slot_next;
    out_key   <= key_next;
    out_time  <= time_next;
    out_size  <= size_next;
    last      <= last_next;
  end

  `PCTT_ASSERT_ALWAYS(a_tok_onehot, clk, rst, $onehot0(tok))
  `PCTT_ASSERT_IMPLIES(a_hit_unique, clk, rst, state == ST_LOOK, $onehot0(hit))
  `PCTT_ASSERT_IMPLIES(a_last_only_del, clk, rst, strobe && !last, event_res == pctt_pkg::EV_DELETED)
  `PCTT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)

endmodule

/* sim/presence_change_tracking_table_top_tb.sv */
// Testbench for presence_change_tracking_table_top: directed and random scans with a
// scoreboard that tracks the table and checks every strobed result in order.
// Depends on pctt_pkg and the RTL of the table.
`timescale 1ns / 1ps

typedef enum bit {
  CMD_REPORT   = 1'b0,
  CMD_END_SCAN = 1'b1
} scan_cmd_t;

typedef struct packed {
  pctt_pkg::pctt_event_t ev;
  logic [4:0]            slot;
  logic [31:0]           key;
  logic [31:0]           stamp;
  logic [31:0]           size;
  logic                  last;
} table_result_t;

class scan_event_board;
  localparam int NSLOTS = pctt_pkg::ENTRIES_DEF;

  logic [31:0]   tab_key[NSLOTS];
  logic [31:0]   tab_stamp[NSLOTS];
  logic [31:0]   tab_size[NSLOTS];
  bit            was_seen[NSLOTS];
  bit            is_seen[NSLOTS];
  table_result_t expected_events[$];
  int            mismatches;

  function new();
    mismatches = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      tab_key[i] = '0;
      tab_stamp[i] = '0;
      tab_size[i] = '0;
      was_seen[i] = 0;
      is_seen[i] = 0;
    end
  endfunction

  function table_result_t entry_event(pctt_pkg::pctt_event_t ev, int idx, logic lst);
    table_result_t r;
    r.ev = ev;
    r.slot = idx[4:0];
    r.key = tab_key[idx];
    r.stamp = tab_stamp[idx];
    r.size = tab_size[idx];
    r.last = lst;
    return r;
  endfunction

  // Accepted command transfer: update the table copy and queue what it causes.
  function void note_command(scan_cmd_t c, logic [31:0] k, logic [31:0] t, logic [31:0] s);
    table_result_t r;
    int hit;
    int free_idx;
    hit = -1;
    free_idx = -1;
    if (c == CMD_REPORT) begin
      for (int i = 0; i < NSLOTS; i++)
        if (hit < 0 && (was_seen[i] || is_seen[i]) && tab_key[i] == k) hit = i;
      if (hit >= 0) begin
        is_seen[hit] = 1;
        if (tab_stamp[hit] != t) begin
          tab_stamp[hit] = t;
          tab_size[hit] = s;
          expected_events.push_back(entry_event(pctt_pkg::EV_CHANGED, hit, 1'b1));
        end
      end else begin
        for (int i = 0; i < NSLOTS; i++)
          if (free_idx < 0 && !was_seen[i] && !is_seen[i]) free_idx = i;
        if (free_idx >= 0) begin
          tab_key[free_idx] = k;
          tab_stamp[free_idx] = t;
          tab_size[free_idx] = s;
          is_seen[free_idx] = 1;
          expected_events.push_back(entry_event(pctt_pkg::EV_ADDED, free_idx, 1'b1));
        end
      end
    end else begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (was_seen[i] && !is_seen[i])
          expected_events.push_back(entry_event(pctt_pkg::EV_DELETED, i, 1'b0));
        was_seen[i] = is_seen[i];
        is_seen[i] = 0;
      end
      r = '0;
      r.ev = pctt_pkg::EV_DONE;
      r.last = 1'b1;
      expected_events.push_back(r);
    end
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_event(table_result_t got);
    table_result_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result ev=%0d slot=%0d key=%h",
                                got.ev, got.slot, got.key));
    end else begin
      want = expected_events.pop_front();
      if (got.ev !== want.ev || got.slot !== want.slot || got.key !== want.key ||
          got.stamp !== want.stamp || got.size !== want.size || got.last !== want.last)
        report_mismatch({
          $sformatf("got ev=%0d slot=%0d key=%h t=%h sz=%h last=%b",
                    got.ev, got.slot, got.key, got.stamp, got.size, got.last),
          $sformatf(", want ev=%0d slot=%0d key=%h t=%h sz=%h last=%b",
                    want.ev, want.slot, want.key, want.stamp, want.size, want.last)});
    end
  endtask

  function int pending();
    return expected_events.size();
  endfunction
endclass

module presence_change_tracking_table_top_tb;
  localparam int NSLOTS = pctt_pkg::ENTRIES_DEF;
  localparam int POOL = 40;
  localparam int ITEMS = 180;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [31:0] item_key;
  logic [31:0] mod_time;
  logic [31:0] item_size;
  logic        strobe;
  logic [1:0]  event_res;
  logic [4:0]  slot;
  logic [31:0] out_key;
  logic [31:0] out_time;
  logic [31:0] out_size;
  logic        last;

  scan_event_board board;
  logic [31:0]     key_pool[POOL];
  bit              no_gaps;
  int              sent;

  presence_change_tracking_table_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_event({pctt_pkg::pctt_event_t'(event_res), slot, out_key, out_time,
                         out_size, last});
  end

  // One command transfer; start stays high across back-to-back items.
  task send_item(scan_cmd_t c, logic [31:0] k, logic [31:0] t, logic [31:0] s);
    int gap;
    if (no_gaps ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 9) == 0))
      no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    item_key <= k;
    mod_time <= t;
    item_size <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(c, k, t, s);
    sent++;
  endtask

  task report_item(logic [31:0] k, logic [31:0] t, logic [31:0] s);
    send_item(CMD_REPORT, k, t, s);
  endtask

  task end_scan();
    send_item(CMD_END_SCAN, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int scan_no;
    int scan_len;
    int offset;
    logic [31:0] k;
    logic [31:0] t;

    board = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = 1'b0;
    item_key = '0;
    mod_time = '0;
    item_size = '0;
    no_gaps = 0;
    sent = 0;
    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, same timestamp, repeated key, deletes, slot reuse
    report_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    report_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    report_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0005);
    report_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA);
    report_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555);
    end_scan();
    report_item(32'h0000_0000, 32'h0000_0001, 32'h1234_5678);
    report_item(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    end_scan();
    end_scan();
    end_scan();
    report_item(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0F0F_F0F0);
    report_item(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hFFFF_0000);
    end_scan();

    // random scans; every fourth one walks a run of the pool longer than the table, to overflow it
    scan_no = 0;
    while (sent < ITEMS) begin
      if (scan_no % 4 == 1) scan_len = $urandom_range(NSLOTS + 2, POOL + 4);
      else scan_len = $urandom_range(0, 10);
      offset = $urandom_range(0, POOL - 1);
      for (int j = 0; j < scan_len && sent < ITEMS; j++) begin
        if (scan_no % 4 == 1 && $urandom_range(0, 7) != 0) k = key_pool[(offset + j) % POOL];
        else if ($urandom_range(0, 6) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, POOL - 1)];
        t = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2)) : $urandom;
        report_item(k, t, $urandom);
      end
      end_scan();
      scan_no++;
    end
    start <= 1'b0;

    for (int n = 0; n < 5000 && board.pending() != 0; n++) @(posedge clk);
    repeat (NSLOTS + 8) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d expected results never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pctt_pkg.sv
rtl/core/pctt_cell.sv
rtl/core/presence_change_tracking_table_top.sv
sim/presence_change_tracking_table_top_tb.sv
